// File: design/sapq_pkg.sv
// Shared types and codes for the sorted-array minimum priority queue.
package sapq_pkg;

  localparam int unsigned DefCapacity = 16;
  localparam int unsigned ValW        = 32;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned OccW        = 5;

  typedef enum logic [StatusW-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Action codes of an input transaction
  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic                   ins;  // insert val in sorted position
    logic                   shl;  // shift toward the head (remove head)
    logic signed [ValW-1:0] val;  // value being inserted
  } cell_ctl_t;

endpackage

// File: design/sapq_cell.sv
// One slot of the sorted chain: compare against the broadcast value and shift.
module sapq_cell (
  input  logic                                clk,
  input  sapq_pkg::cell_ctl_t                 ctl,
  input  logic                                prev_occ,
  input  logic signed [sapq_pkg::ValW-1:0]    prev_val,
  input  logic                                own_occ,
  input  logic signed [sapq_pkg::ValW-1:0]    next_val,
  output logic signed [sapq_pkg::ValW-1:0]    val
);

  logic signed [sapq_pkg::ValW-1:0] val_r;
  logic signed [sapq_pkg::ValW-1:0] val_nxt;
  logic                             prev_gt;
  logic                             own_gt;

  // Strict compare keeps equal values in arrival order
  assign prev_gt = prev_occ && (prev_val > ctl.val);
  assign own_gt  = own_occ && (val_r > ctl.val);

  // Pick the next content of this slot
  always_comb begin
    val_nxt = val_r;
    priority if (ctl.ins) begin
      if (prev_gt) begin
        val_nxt = prev_val;
      end else if (own_gt || !own_occ) begin
        val_nxt = ctl.val;
      end
    end else if (ctl.shl) begin
      val_nxt = next_val;
    end else begin
      val_nxt = val_r;
    end
  end

  // Hold payload; no reset needed
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

// File: design/sorted_array_min_priority_queue.sv
// Top level: controller, fill count, cell chain and result register.
//
// Sorted-array minimum priority queue. Values sit in a row of CAPACITY cells in
// ascending signed order; an enqueue is compared in every cell at once and the
// larger values shift one cell toward the tail, a dequeue shifts the whole row
// one cell toward the head and returns the old head. Each transaction puts its
// result in the result register in the cycle after, so a new transaction is
// taken every cycle while results are being drained; the per-cell compare
// against the broadcast value sets the cycle time. A full queue drops an
// enqueued value (status 1), an empty queue answers a dequeue with 0 (status 2).
// The occupancy field is the fill count kept to its low 5 bits.
module sorted_array_min_priority_queue #(
  parameter int unsigned CAPACITY = sapq_pkg::DefCapacity
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_action,
  input  logic signed [sapq_pkg::ValW-1:0]     in_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [sapq_pkg::StatusW-1:0]         out_status,
  output logic signed [sapq_pkg::ValW-1:0]     out_removed,
  output logic [sapq_pkg::OccW-1:0]            out_occupancy
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  logic [CntW-1:0]                  cnt_r;
  logic [CntW-1:0]                  cnt_nxt;
  logic                             out_valid_r;
  sapq_pkg::status_t                out_status_r;
  logic signed [sapq_pkg::ValW-1:0] out_removed_r;
  logic [sapq_pkg::OccW-1:0]        out_occ_r;
  sapq_pkg::status_t                status;
  logic signed [sapq_pkg::ValW-1:0] removed;
  logic [CntW+sapq_pkg::OccW-1:0]   cnt_ext;
  logic                             accept;
  logic                             full;
  logic                             empty;
  sapq_pkg::cell_ctl_t              ctl;
  logic [CAPACITY-1:0]              occ;
  logic signed [sapq_pkg::ValW-1:0] cell_val [CAPACITY];

  // Accept while the result register is free or being drained
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (cnt_r == CapCnt);
  assign empty    = (cnt_r == '0);

  // Decode the transaction into the broadcast and the new count
  always_comb begin
    ctl.ins = 1'b0;
    ctl.shl = 1'b0;
    ctl.val = in_value;
    status  = sapq_pkg::ST_DONE;
    removed = '0;
    cnt_nxt = cnt_r;
    unique case (in_action)
      sapq_pkg::ACT_ENQ: begin
        if (full) begin
          status = sapq_pkg::ST_FULL;
        end else begin
          ctl.ins = accept;
          cnt_nxt = cnt_r + CntW'(1);
        end
      end
      sapq_pkg::ACT_DEQ: begin
        if (empty) begin
          status = sapq_pkg::ST_EMPTY;
        end else begin
          ctl.shl = accept;
          removed = cell_val[0];
          cnt_nxt = cnt_r - CntW'(1);
        end
      end
      default: ;
    endcase
  end

  assign cnt_ext = {{sapq_pkg::OccW{1'b0}}, cnt_nxt};

  // Slot is occupied when its index lies below the count
  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic                             p_occ;
      logic signed [sapq_pkg::ValW-1:0] p_val;
      logic signed [sapq_pkg::ValW-1:0] n_val;

      assign occ[gi] = (CntW'(gi) < cnt_r);

      if (gi == 0) begin : g_head
        assign p_occ = 1'b0;
        assign p_val = cell_val[gi];
      end else begin : g_mid
        assign p_occ = occ[gi-1];
        assign p_val = cell_val[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_tail
        assign n_val = cell_val[gi];
      end else begin : g_body
        assign n_val = cell_val[gi+1];
      end

      sapq_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .prev_occ (p_occ),
        .prev_val (p_val),
        .own_occ  (occ[gi]),
        .next_val (n_val),
        .val      (cell_val[gi])
      );
    end
  endgenerate

  // Advance the fill count and the result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load the result payload with each transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r  <= status;
      out_removed_r <= removed;
      out_occ_r     <= cnt_ext[sapq_pkg::OccW-1:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_removed   = out_removed_r;
  assign out_occupancy = out_occ_r;

  // Count never passes the capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CapCnt)
    else $error("fill count above capacity");

  // An accepted enqueue into a non-full queue grows the count by one
  a_enq_grow: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_action == sapq_pkg::ACT_ENQ) && !full |=>
      cnt_r == $past(cnt_r) + CntW'(1))
    else $error("enqueue did not grow the count");

  // An accepted dequeue from a non-empty queue shrinks the count by one
  a_deq_shrink: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_action == sapq_pkg::ACT_DEQ) && !empty |=>
      cnt_r == $past(cnt_r) - CntW'(1))
    else $error("dequeue did not shrink the count");

  // A successful dequeue returns the old head
  a_deq_head: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_action == sapq_pkg::ACT_DEQ) && !empty |=>
      out_removed_r == $past(cell_val[0]))
    else $error("dequeue returned something other than the head");

endmodule

// File: test/tb_top.sv
// Testbench for the sorted-array minimum priority queue: driver, checker and queue predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned ValW     = sapq_pkg::ValW;
  localparam int unsigned OccW     = sapq_pkg::OccW;
  localparam int unsigned StatusW  = sapq_pkg::StatusW;
  localparam int unsigned QCap     = sapq_pkg::DefCapacity;
  localparam int unsigned NumItems = 1100;
  localparam int unsigned LongHold = 80;

  typedef struct {
    logic                   action;
    logic signed [ValW-1:0] value;
    bit                     drain_first;  // wait for every result before offering
  } pq_op_t;

  typedef struct {
    sapq_pkg::status_t      status;
    logic signed [ValW-1:0] removed;
    logic [OccW-1:0]        occupancy;
  } pq_result_t;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   in_action = sapq_pkg::ACT_ENQ;
  logic signed [ValW-1:0] in_value = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [StatusW-1:0]     out_status;
  logic signed [ValW-1:0] out_removed;
  logic [OccW-1:0]        out_occupancy;

  // Predictor state: values held in ascending order
  logic signed [ValW-1:0] sorted_vals[$];
  pq_result_t             result_want_q[$];
  pq_op_t                 op_q[$];

  int  n_errors = 0;
  int  n_sent = 0;
  int  n_recv = 0;
  int  n_enq = 0;
  int  n_deq = 0;
  int  n_dropped = 0;
  int  n_empty_deq = 0;
  int  tx_wait = 0;
  int  rx_wait = 0;
  bit  tx_burst = 1'b0;
  bit  rx_burst = 1'b0;

  sorted_array_min_priority_queue #(
    .CAPACITY(QCap)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_removed  (out_removed),
    .out_occupancy(out_occupancy)
  );

  always #5 clk = ~clk;

  // Apply one transaction to the predicted store and return its result
  function automatic pq_result_t queue_apply(logic act, logic signed [ValW-1:0] val);
    pq_result_t r;
    int         pos;
    r.status  = sapq_pkg::ST_DONE;
    r.removed = '0;
    if (act == sapq_pkg::ACT_ENQ) begin
      n_enq++;
      if (sorted_vals.size() >= QCap) begin
        r.status = sapq_pkg::ST_FULL;
        n_dropped++;
      end else begin
        // insert after any equal values
        pos = sorted_vals.size();
        while (pos > 0 && sorted_vals[pos-1] > val) pos--;
        sorted_vals.insert(pos, val);
      end
    end else begin
      n_deq++;
      if (sorted_vals.size() == 0) begin
        r.status = sapq_pkg::ST_EMPTY;
        n_empty_deq++;
      end else begin
        r.removed = sorted_vals.pop_front();
      end
    end
    r.occupancy = OccW'(sorted_vals.size());
    return r;
  endfunction

  // Wait length for one transaction, with occasional runs of back-to-back traffic
  function automatic int draw_wait(inout bit burst);
    if ($urandom_range(0, 39) == 0) burst = ~burst;
    return burst ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic logic signed [ValW-1:0] draw_value();
    case ($urandom_range(0, 9))
      5, 6:    return $signed(ValW'($urandom_range(0, 20))) - 10;
      7:       return 32'sh7FFF_FFFF;
      8:       return 32'sh8000_0000;
      9:       return $signed(32'h8000_0000 ^ ValW'($urandom_range(0, 3)));
      default: return $signed(ValW'($urandom));
    endcase
  endfunction

  task automatic add_op(logic act, logic signed [ValW-1:0] val, bit drain);
    pq_op_t op;
    op.action      = act;
    op.value       = val;
    op.drain_first = drain;
    op_q.push_back(op);
  endtask

  task automatic report_mismatch(string what, longint want, longint got);
    n_errors++;
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  // Driver: offer queued transactions, hold the payload while stalled
  always @(posedge clk) begin : drv
    logic   nxt_valid;
    pq_op_t op;
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait = 0;
    end else begin
      nxt_valid = in_valid;
      if (in_valid && !in_stall) begin
        result_want_q.push_back(queue_apply(in_action, in_value));
        n_sent++;
        nxt_valid = 1'b0;
        tx_wait = draw_wait(tx_burst);
      end
      if (!nxt_valid) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (op_q.size() > 0 &&
                     !(op_q[0].drain_first && result_want_q.size() != 0)) begin
          op = op_q.pop_front();
          in_action <= op.action;
          in_value  <= op.value;
          nxt_valid = 1'b1;
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // Monitor: check each result against the oldest prediction, drive random stall
  always @(posedge clk) begin : mon
    pq_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_recv++;
        if (result_want_q.size() == 0) begin
          report_mismatch("unexpected result status", -1, out_status);
        end else begin
          want = result_want_q.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", want.status, out_status);
          if (out_removed !== want.removed)
            report_mismatch("removed", want.removed, out_removed);
          if (out_occupancy !== want.occupancy)
            report_mismatch("occupancy", want.occupancy, out_occupancy);
        end
        rx_wait = draw_wait(rx_burst);
        // long hold-off so the block backs up into its input
        if (n_recv == 250 || n_recv == 650) rx_wait = LongHold;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin : main
    mix_t mode;
    int   run_len;
    int   pct_enq;
    logic act;
    bit   drain;

    // Directed: empty dequeue, extremes, duplicates, fill, overflow, full dequeue
    add_op(sapq_pkg::ACT_DEQ, 32'sh7FFF_FFFF, 1'b0);
    add_op(sapq_pkg::ACT_ENQ, 32'sh7FFF_FFFF, 1'b0);
    add_op(sapq_pkg::ACT_ENQ, 32'sh8000_0000, 1'b0);
    add_op(sapq_pkg::ACT_ENQ, 32'sd0, 1'b0);
    add_op(sapq_pkg::ACT_ENQ, -32'sd1, 1'b0);
    add_op(sapq_pkg::ACT_ENQ, 32'sd1, 1'b0);
    add_op(sapq_pkg::ACT_ENQ, 32'sh8000_0000, 1'b0);
    add_op(sapq_pkg::ACT_DEQ, 32'sd0, 1'b0);
    add_op(sapq_pkg::ACT_DEQ, -32'sd1, 1'b0);
    for (int i = 0; i < 12; i++) add_op(sapq_pkg::ACT_ENQ, draw_value(), 1'b0);
    add_op(sapq_pkg::ACT_ENQ, 32'sh8000_0000, 1'b0);
    add_op(sapq_pkg::ACT_DEQ, 32'sd5, 1'b0);

    // Random: phases that lean toward filling, draining or neither
    while (op_q.size() < NumItems) begin
      mode    = mix_t'($urandom_range(0, 2));
      run_len = $urandom_range(10, 60);
      pct_enq = (mode == MIX_FILL) ? 80 : (mode == MIX_DRAIN) ? 20 : 50;
      for (int i = 0; i < run_len; i++) begin
        act   = ($urandom_range(0, 99) < pct_enq) ? sapq_pkg::ACT_ENQ : sapq_pkg::ACT_DEQ;
        drain = (op_q.size() == 500 || op_q.size() == 900);
        add_op(act, draw_value(), drain);
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (op_q.size() != 0 || in_valid || result_want_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (result_want_q.size() != 0)
      report_mismatch("results still outstanding", 0, result_want_q.size());

    $display("Ran %0d enqueues (%0d dropped on a full store) and %0d dequeues (%0d on empty)",
             n_enq, n_dropped, n_deq, n_empty_deq);
    $display("Checked %0d results against the predictor, %0d mismatches", n_recv, n_errors);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #2_000_000;
    $display("Timed out with %0d results outstanding", result_want_q.size());
    $display("FAILURE");
    $finish;
  end

endmodule

// File: sorted_array_min_priority_queue.f
design/sapq_pkg.sv
design/sapq_cell.sv
design/sorted_array_min_priority_queue.sv
test/tb_top.sv
